// ----- rtl/b58enc_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base58 encoder.
// No dependencies; imported by base58_encoder_top and tb_top.
package b58enc_pkg;

   localparam int MAX_BYTES_DEF   = 32;
   localparam int DIGIT_DEPTH_DEF = 44;

   localparam int BYTE_W  = 8;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;
   localparam int CARRY_W = 8;
   localparam int VAL_W   = DIGIT_W + BYTE_W;

   localparam logic [VAL_W-1:0] BASE = VAL_W'(58);

   // floor(2^20 / 58); estimate is exact or one low over the whole value range
   localparam int                 RECIP_SHIFT = 20;
   localparam int                 RECIP_W     = 15;
   localparam logic [RECIP_W-1:0] RECIP_58    = RECIP_W'(18078);
   localparam int                 PROD_W      = VAL_W + RECIP_W;

   localparam logic [CHAR_W-1:0] CHAR_ONE = CHAR_W'(49);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_FIX,
      ST_EMIT_ZERO,
      ST_EMIT_RD,
      ST_EMIT_PUT
   } state_type;

   function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = CHAR_W'(d);
      if (d < DIGIT_W'(9))       return CHAR_W'(49) + dx;               // 1..9
      else if (d < DIGIT_W'(17)) return CHAR_W'(65) + dx - CHAR_W'(9);  // A..H
      else if (d < DIGIT_W'(22)) return CHAR_W'(74) + dx - CHAR_W'(17); // J..N
      else if (d < DIGIT_W'(33)) return CHAR_W'(80) + dx - CHAR_W'(22); // P..Z
      else if (d < DIGIT_W'(44)) return CHAR_W'(97) + dx - CHAR_W'(33); // a..k
      else if (d < DIGIT_W'(58)) return CHAR_W'(109) + dx - CHAR_W'(44); // m..z
      else                       return CHAR_ONE;
   endfunction

endpackage

// ----- rtl/b58enc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module b58enc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/base58_encoder_top.sv -----
// Base58 (Bitcoin alphabet) encoder: byte stream in, ASCII character stream out.
// Depends on b58enc_pkg and b58enc_ram (digit store).
// Input: each byte is folded into the stored digits one digit at a time (ST_READ, ST_MUL,
// ST_FIX; appended digits skip ST_READ), bounded by the one shared divide-by-58 unit.
// Output: each leading '1' goes out directly; each digit is first read from the digit store.
// Synchronous active-high reset clears all control state; the digit store is not cleared.
module base58_encoder_top #(
   parameter int MAX_BYTES   = b58enc_pkg::MAX_BYTES_DEF,
   parameter int DIGIT_DEPTH = b58enc_pkg::DIGIT_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] char_code, [7] zero
   output logic       rsp_tlast,   // last_char
   output logic       rsp_tuser    // [0] overflow
);

   import b58enc_pkg::*;

   localparam int CNT_W   = $clog2(DIGIT_DEPTH + 1);
   localparam int IDX_W   = $clog2(DIGIT_DEPTH);
   localparam int BYTES_W = $clog2(MAX_BYTES + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [BYTES_W-1:0]   zp_ff, zp_in;
   logic                 prefix_ff, prefix_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [CARRY_W-1:0]   carry_ff, carry_in;
   logic [VAL_W-1:0]     v_ff, v_in;
   logic [CARRY_W-1:0]   q_ff, q_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [DIGIT_W-1:0]   wr_data, rd_data;

   logic [DIGIT_W-1:0]   digit;
   logic [PROD_W-1:0]    prod;
   logic [VAL_W-1:0]     rem;
   logic [CARRY_W-1:0]   q_fix;
   logic [CNT_W-1:0]     k_next;
   logic                 slot;
   state_type            end_state;

   b58enc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DIGIT_DEPTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (k_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         zp_ff        <= '0;
         prefix_ff    <= 1'b1;
         bytes_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         zp_ff        <= zp_in;
         prefix_ff    <= prefix_in;
         bytes_ff     <= bytes_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      carry_ff    <= carry_in;
      v_ff        <= v_in;
      q_ff        <= q_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      zp_in        = zp_ff;
      prefix_in    = prefix_ff;
      bytes_in     = bytes_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      carry_in     = carry_ff;
      v_in         = v_ff;
      q_in         = q_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = k_ff[IDX_W-1:0];
      slot         = !out_valid_ff || rsp_tready;
      end_state    = last_ff ? ST_EMIT_ZERO : ST_IDLE;

      // divide-by-58 unit: reciprocal estimate, then one correction step
      digit   = (k_ff < count_ff) ? rd_data : '0;
      prod    = PROD_W'({digit, 8'b0} + VAL_W'(carry_ff)) * PROD_W'(RECIP_58);
      rem     = v_ff - VAL_W'(q_ff) * BASE;
      q_fix   = q_ff;
      if (rem >= BASE) begin
         rem   = rem - BASE;
         q_fix = q_ff + CARRY_W'(1);
      end
      wr_data = rem[DIGIT_W-1:0];
      k_next  = k_ff + CNT_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in   = req_tlast;
               end_state = req_tlast ? ST_EMIT_ZERO : ST_IDLE;
               state_in  = end_state;
               if (bytes_ff < BYTES_W'(MAX_BYTES)) begin
                  bytes_in = bytes_ff + BYTES_W'(1);
                  if (prefix_ff && req_tdata == 8'd0) begin
                     zp_in = zp_ff + BYTES_W'(1);
                  end else begin
                     prefix_in = 1'b0;
                     carry_in  = req_tdata;
                     k_in      = '0;
                     if (count_ff != '0) begin
                        state_in = ST_READ;
                     end else if (req_tdata != 8'd0) begin
                        state_in = ST_MUL;
                     end
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            v_in     = {digit, 8'b0} + VAL_W'(carry_ff);
            q_in     = prod[RECIP_SHIFT +: CARRY_W];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            wr_en    = 1'b1;
            carry_in = q_fix;
            k_in     = k_next;
            if (k_ff >= count_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (k_next < count_ff) begin
               state_in = ST_READ;
            end else if (q_fix != '0 && count_in < CNT_W'(DIGIT_DEPTH)) begin
               state_in = ST_MUL;
            end else begin
               state_in = end_state;
            end
         end
         ST_EMIT_ZERO: begin
            if (zp_ff == '0) begin
               if (count_ff != '0) begin
                  k_in     = count_ff - CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (slot) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ONE;
               out_last_in  = (zp_ff == BYTES_W'(1)) && (count_ff == '0);
               out_ovf_in   = ovf_ff;
               zp_in        = zp_ff - BYTES_W'(1);
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_PUT;
         end
         ST_EMIT_PUT: begin
            if (slot) begin
               out_valid_in = 1'b1;
               out_char_in  = b58_char(rd_data);
               out_last_in  = (k_ff == '0);
               out_ovf_in   = ovf_ff;
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff - CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // message done: back to the empty state
      if ((state_ff == ST_EMIT_ZERO || state_ff == ST_EMIT_PUT) && state_in == ST_IDLE) begin
         count_in  = '0;
         zp_in     = '0;
         prefix_in = 1'b1;
         bytes_in  = '0;
         ovf_in    = 1'b0;
         last_in   = 1'b0;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule

// ----- rtl/b58enc_checker.sv -----
// Port-level checks for base58_encoder_top, bound to every instance.
// No dependencies.
module b58enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_rsp_flags_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp flags changed while stalled");

   // every character is inside the alphabet's code range
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7] == 1'b0 && rsp_tdata >= 8'd49 && rsp_tdata <= 8'd122)
      else $error("character code out of range");

   // no new byte taken while a string is still being emitted
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready in the middle of an encoded string");

endmodule

bind base58_encoder_top b58enc_checker u_b58enc_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for base58_encoder_top: byte messages go in, and the
// ASCII characters that come out are checked against an in-bench base58 encoder.
// Depends on b58enc_pkg and the base58_encoder_top RTL.
module tb_top;
   import b58enc_pkg::*;

   localparam int MSG_MAX     = MAX_BYTES_DEF;
   localparam int STORE_DEPTH = DIGIT_DEPTH_DEF;
   localparam string B58_ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
      logic              ovf;
   } char_beat_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tlast  = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [6:0] char_code, [7] zero
   logic       rsp_tlast;            // last_char
   logic       rsp_tuser;            // [0] overflow

   base58_encoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #10_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // encoder state mirror
   logic [DIGIT_W-1:0] digits [STORE_DEPTH];
   logic [5:0]         ndigits    = '0;
   logic [5:0]         zero_run   = '0;
   logic               in_prefix  = 1'b1;
   logic [6:0]         taken      = '0;
   logic               dropped    = 1'b0;

   char_beat_type expected_chars [$];
   int            error_count = 0;
   int            bytes_sent  = 0;
   int            burst_left  = 0;

   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      int            carry;
      int            k;
      int            total;
      int            n;
      byte           ch;
      char_beat_type beat;
      if (taken < MSG_MAX) begin
         if (in_prefix && b == 8'h00) begin
            zero_run++;
         end else begin
            in_prefix = 1'b0;
            carry = b;
            for (k = 0; k < ndigits; k++) begin
               carry = carry + 256 * digits[k];
               digits[k] = DIGIT_W'(carry % 58);
               carry = carry / 58;
            end
            while (carry > 0 && ndigits < STORE_DEPTH) begin
               digits[ndigits] = DIGIT_W'(carry % 58);
               ndigits++;
               carry = carry / 58;
            end
         end
         taken++;
      end else begin
         dropped = 1'b1;
      end
      if (!fin) return;
      total = zero_run + ndigits;
      n = 0;
      for (k = 0; k < zero_run; k++) begin
         ch = B58_ALPHABET[0];
         beat.code = ch[6:0];
         beat.last = (n + 1 == total);
         beat.ovf  = dropped;
         expected_chars.push_back(beat);
         n++;
      end
      for (k = ndigits; k > 0; k--) begin
         ch = B58_ALPHABET[digits[k-1]];
         beat.code = ch[6:0];
         beat.last = (n + 1 == total);
         beat.ovf  = dropped;
         expected_chars.push_back(beat);
         n++;
      end
      ndigits   = '0;
      zero_run  = '0;
      in_prefix = 1'b1;
      taken     = '0;
      dropped   = 1'b0;
   endfunction

   // receiver: the stall mode is redrawn each time stall_phase wraps to zero
   logic [5:0] stall_phase = '0;
   logic [1:0] stall_mode  = '0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= stall_phase[2];
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin : check_chars
      char_beat_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected char beat: tdata=%h tlast=%b tuser=%b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== {1'b0, want.code}) begin
               $display("%0t: char_code expected %h, got %h",
                        $time, {1'b0, want.code}, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_char expected %b, got %b", $time, want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.ovf) begin
               $display("%0t: overflow expected %b, got %b", $time, want.ovf, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // one beat in; valid stays high across a burst, drops for a random gap after it
   task automatic send_beat(input logic [7:0] b, input logic fin);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      encode_byte(b, fin);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 8'h00;
      if (r == 2) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_message(input int len, input int lead);
      int k;
      for (k = 0; k < len; k++)
         send_beat((k < lead) ? 8'h00 : pick_byte(), k == len - 1);
   endtask

   task automatic send_const(input int len, input logic [7:0] b);
      int k;
      for (k = 0; k < len; k++) send_beat(b, k == len - 1);
   endtask

   task automatic test_single_bytes();
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h01, 1'b1);
      send_beat(8'h39, 1'b1);
      send_beat(8'h3A, 1'b1);
   endtask

   task automatic test_zero_prefix();
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h01, 1'b1);
      send_const(3, 8'h00);
      send_beat(8'h00, 1'b0);
      send_beat(8'h05, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_beat(8'hA5, 1'b0);
      send_beat(8'h5A, 1'b1);
      wait_drained();
      send_beat(8'h80, 1'b1);
   endtask

   task automatic test_long_messages();
      send_const(MSG_MAX, 8'hFF);
      send_const(MSG_MAX, 8'h00);
      send_message(MSG_MAX, 3);
   endtask

   task automatic test_overflow();
      send_message(MSG_MAX + 1, 0);
      send_message(MSG_MAX + $urandom_range(2, 6), 2);
   endtask

   task automatic test_random_messages(input int target);
      int kind;
      int lead;
      while (bytes_sent < target) begin
         kind = $urandom_range(0, 99);
         lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
         if (kind < 55)      send_message($urandom_range(1, 6), lead);
         else if (kind < 82) send_message($urandom_range(7, 20), lead);
         else if (kind < 90) send_message($urandom_range(21, MSG_MAX), lead);
         else if (kind < 95) send_message(MSG_MAX + $urandom_range(1, 5), lead);
         else                send_const($urandom_range(1, MSG_MAX), 8'h00);
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_bytes();
      test_zero_prefix();
      test_drain_pause();
      test_long_messages();
      test_overflow();
      test_random_messages(460);
      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- base58_encoder_top.f -----
rtl/b58enc_pkg.sv
rtl/b58enc_ram.sv
rtl/base58_encoder_top.sv
rtl/b58enc_checker.sv
tb/tb_top.sv
